[rtl/core/sdsf_pkg.sv]
// ----------------------------------------------------------------------------
// sdsf_pkg
// Shared types, symbol codes and the segment table of the signed decimal
// seven-segment formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsf_pkg;

	localparam logic [3:0] SYM_BLANK = 4'd10;
	localparam logic [3:0] SYM_MINUS = 4'd11;

	// register index decoded from paddr[2]
	localparam logic REG_DIGITS_IN_USE = 1'b0;

	localparam logic [3:0] DIGITS_RESET = 4'd4;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	typedef struct packed {
		logic       done;
		logic [3:0] digit;
		logic       qzero;
	} div_stat_t;

	// segment pattern before inversion, bit order c d e g b a P f
	function automatic logic [7:0] seg_pattern(input logic [3:0] sym);
		logic [7:0] pat;
		case (sym)
			4'd0:      pat = 8'hEF;
			4'd1:      pat = 8'h8A;
			4'd2:      pat = 8'h7E;
			4'd3:      pat = 8'hDE;
			4'd4:      pat = 8'h9B;
			4'd5:      pat = 8'hD7;
			4'd6:      pat = 8'hF7;
			4'd7:      pat = 8'h8E;
			4'd8:      pat = 8'hFF;
			4'd9:      pat = 8'hDF;
			SYM_BLANK: pat = 8'h02;
			SYM_MINUS: pat = 8'h12;
			default:   pat = 8'h02;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

[rtl/core/signed_decimal_seven_segment_formatter_core.sv]
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_formatter_core
// Formats a signed 32-bit value as active-low seven-segment digit codes.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on start while busy is low. The value's magnitude
//   is divided by ten nibble-serially, and each digit is shown on the result
//   ports for one cycle with strobe high, least significant place first.
//   last_digit marks the final one. busy stays high while a value's digits
//   are produced, so a new value is taken only once the final digit is out.
//   digits_in_use (APB, byte address 0) sets the place count, clamped to the
//   smaller of MAX_DIGITS and 8; 0 gives no results and busy stays low.
//   Leading zero places are blank; a negative value puts its minus sign in
//   the first such place, dropped when none is left.
//   Reset returns to idle with digits_in_use at 4. The receiver cannot stall:
//   each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_seven_segment_formatter_core
	import sdsf_pkg::*;
#(
	parameter int MAX_DIGITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] value,
	output logic                    strobe,
	output logic      [7:0]         segment_code,
	output logic      [3:0]         symbol,
	output logic      [2:0]         digit_position,
	output logic                    last_digit
);

	localparam int         LIMIT   = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
	localparam logic [3:0] LIMIT_W = 4'(LIMIT);

	state_t      state_q;
	logic [3:0]  digits_q;
	logic [2:0]  pos_q;
	logic [2:0]  last_pos_q;
	logic        pend_q;

	logic        accept;
	logic        neg;
	logic [31:0] mag;
	logic [3:0]  count;
	logic [3:0]  sym;
	logic        take_minus;
	div_ctrl_t   ctrl;
	div_stat_t   stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIGITS_IN_USE) ? {28'd0, digits_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= DIGITS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DIGITS_IN_USE)) begin
			digits_q <= pwdata[3:0];
		end
	end

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;
	assign neg    = value[31];
	assign mag    = neg ? (32'd0 - value) : value;
	assign count  = (digits_q > LIMIT_W) ? LIMIT_W : digits_q;

	assign ctrl.load = accept;
	assign ctrl.step = busy;

	sdsf_div10 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.mag    (mag),
		.stat   (stat)
	);

	always_comb begin
		sym        = stat.digit;
		take_minus = 1'b0;
		if ((stat.digit == 4'd0) && stat.qzero) begin
			if (pend_q) begin
				sym        = SYM_MINUS;
				take_minus = 1'b1;
			end else if (pos_q != 3'd0) begin
				sym = SYM_BLANK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= 3'd0;
			last_pos_q <= 3'd0;
			pend_q     <= 1'b0;
			strobe     <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (count != 4'd0)) begin
						state_q    <= ST_RUN;
						pos_q      <= 3'd0;
						last_pos_q <= 3'(count - 4'd1);
						pend_q     <= neg;
					end
				end
				ST_RUN: begin
					if (stat.done) begin
						strobe <= 1'b1;
						pos_q  <= pos_q + 3'd1;
						if (take_minus) begin
							pend_q <= 1'b0;
						end
						if (pos_q == last_pos_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (busy && stat.done) begin
			segment_code   <= ~seg_pattern(sym);
			symbol         <= sym;
			digit_position <= pos_q;
			last_digit     <= (pos_q == last_pos_q);
		end
	end

`ifndef SYNTHESIS
	a_strobe_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_RUN))
		else $error("result strobe without a running transaction");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_digit) |-> !busy)
		else $error("still busy after final digit");

	a_strobe_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("results closer than one digit period");

	a_place0_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (digit_position == 3'd0)) |-> (symbol != SYM_BLANK))
		else $error("least significant place shown blank");
`endif

endmodule

`default_nettype wire

[rtl/core/sdsf_div10.sv]
// ----------------------------------------------------------------------------
// sdsf_div10
// Nibble-serial divide by ten, one 4-bit dividend digit per cycle while step is
// high: quotient shifted back into the same register, remainder on the last nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsf_div10
	import sdsf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_ctrl_t   ctrl,
	input  wire logic [31:0] mag,
	output div_stat_t        stat
);

	logic [31:0] mag_q;
	logic [3:0]  rem_q;
	logic [2:0]  nib_q;
	logic        qnz_q;

	logic [7:0]  x;
	logic [15:0] prod;
	logic [3:0]  q;
	logic [7:0]  r8;

	// x < 160, so x*205 >> 11 is an exact x/10
	assign x    = {rem_q, mag_q[31:28]};
	assign prod = {8'd0, x} * 16'd205;
	assign q    = prod[14:11];
	assign r8   = x - ({3'd0, q, 1'b0} + {1'b0, q, 3'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_q <= 3'd0;
		end else if (ctrl.load) begin
			nib_q <= 3'd0;
		end else if (ctrl.step) begin
			nib_q <= nib_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= mag;
			rem_q <= 4'd0;
			qnz_q <= 1'b0;
		end else if (ctrl.step) begin
			mag_q <= {mag_q[27:0], q};
			if (nib_q == 3'd7) begin
				rem_q <= 4'd0;
				qnz_q <= 1'b0;
			end else begin
				rem_q <= r8[3:0];
				qnz_q <= qnz_q | (q != 4'd0);
			end
		end
	end

	assign stat.done  = ctrl.step && (nib_q == 3'd7);
	assign stat.digit = r8[3:0];
	assign stat.qzero = !(qnz_q || (q != 4'd0));

endmodule

`default_nettype wire

[tb/sv/signed_decimal_seven_segment_formatter_core_tb.sv]
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_formatter_core_tb
// Drives values through the formatter and checks every digit code. A short
// directed table covers the field extremes, every symbol, blanking, the minus
// sign and the digit count limits. Random phases then follow, each with its
// own digit count. Typed rows list their digits; the rest use a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_seven_segment_formatter_core_tb;
	import sdsf_pkg::*;

	localparam int         LIMIT_TIME    = 3_000_000;
	localparam int         SETTLE_CYCLES = 80;
	localparam int         DIGIT_CLAMP   = 8;
	localparam int         RANDOM_PHASES = 14;
	localparam int         PHASE_ITEMS   = 30;
	localparam int         DIR_ROWS      = 25;
	localparam logic [2:0] ADDR_DIGITS   = {REG_DIGITS_IN_USE, 2'b00};
	localparam logic [3:0] BL            = SYM_BLANK;
	localparam logic [3:0] MI            = SYM_MINUS;

	typedef struct packed {
		logic [7:0] seg;
		logic [3:0] sym;
		logic [2:0] pos;
		logic       last;
	} digit_t;

	// syms holds one symbol per place, place 0 in the low nibble
	typedef struct packed {
		logic [3:0]  ndig;
		logic [31:0] val;
		logic        typed;
		logic [31:0] syms;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic signed [31:0] value;
	logic               strobe;
	logic [7:0]         segment_code;
	logic [3:0]         symbol;
	logic [2:0]         digit_position;
	logic               last_digit;

	digit_t     pending_digits[$];
	digit_t     next_digit;
	dir_row_t   dir_table [DIR_ROWS];
	logic [3:0] digit_count;
	int         err_count;
	int         digits_seen;
	int         values_sent;
	int         count_settings;

	signed_decimal_seven_segment_formatter_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.strobe         (strobe),
		.segment_code   (segment_code),
		.symbol         (symbol),
		.digit_position (digit_position),
		.last_digit     (last_digit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_TIME);
		$display("timeout with %0d digits outstanding", pending_digits.size());
		$display("DONE: errors detected");
		$finish;
	end

	// active-high segment pattern, bit order c d e g b a P f
	function automatic logic [7:0] seg_on(logic [3:0] sym);
		case (sym)
			4'd0:      return 8'b11101111;
			4'd1:      return 8'b10001010;
			4'd2:      return 8'b01111110;
			4'd3:      return 8'b11011110;
			4'd4:      return 8'b10011011;
			4'd5:      return 8'b11010111;
			4'd6:      return 8'b11110111;
			4'd7:      return 8'b10001110;
			4'd8:      return 8'b11111111;
			4'd9:      return 8'b11011111;
			SYM_BLANK: return 8'b00000010;
			SYM_MINUS: return 8'b00010010;
			default:   return 8'b00000000;
		endcase
	endfunction

	function automatic int places(logic [3:0] ndig);
		return (ndig > DIGIT_CLAMP) ? DIGIT_CLAMP : int'(ndig);
	endfunction

	function automatic void push_digit(logic [3:0] sym, int j, int cnt);
		digit_t d;
		d.seg  = ~seg_on(sym);
		d.sym  = sym;
		d.pos  = j[2:0];
		d.last = (j + 1 == cnt);
		pending_digits.push_back(d);
	endfunction

	function automatic void predict_digits(logic [31:0] raw, logic [3:0] ndig);
		logic [31:0] mag;
		logic [3:0]  sym;
		logic        minus_left;
		int          cnt;
		cnt        = places(ndig);
		mag        = raw[31] ? -raw : raw;
		minus_left = raw[31];
		for (int j = 0; j < cnt; j++) begin
			sym = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			if (sym == 4'd0 && mag == 32'd0) begin
				if (minus_left) begin
					sym        = SYM_MINUS;
					minus_left = 1'b0;
				end else if (j > 0) begin
					sym = SYM_BLANK;
				end
			end
			push_digit(sym, j, cnt);
		end
	endfunction

	function automatic void typed_digits(logic [31:0] syms, logic [3:0] ndig);
		int cnt;
		cnt = places(ndig);
		for (int j = 0; j < cnt; j++)
			push_digit(syms[4*j +: 4], j, cnt);
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		logic [31:0] p;
		case ($urandom_range(0, 5))
			0: v = 32'($urandom_range(0, 999));
			1: v = 32'($urandom_range(0, 99_999_999));
			2: begin
				p = 32'd1;
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				v = p + 32'($urandom_range(0, 2)) - 32'd1;
			end
			3: begin
				case ($urandom_range(0, 4))
					0:       v = 32'h0000_0000;
					1:       v = 32'hFFFF_FFFF;
					2:       v = 32'h7FFF_FFFF;
					3:       v = 32'h8000_0000;
					default: v = 32'h8000_0001;
				endcase
				return v;
			end
			default: return $urandom();
		endcase
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (err_count < 40)
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			digits_seen++;
			if (pending_digits.size() == 0) begin
				report_mismatch("digit with none pending", {28'd0, symbol}, 32'd0);
			end else begin
				next_digit = pending_digits.pop_front();
				if (segment_code !== next_digit.seg)
					report_mismatch("segment_code", 32'(segment_code),
						32'(next_digit.seg));
				if (symbol !== next_digit.sym)
					report_mismatch("symbol", 32'(symbol), 32'(next_digit.sym));
				if (digit_position !== next_digit.pos)
					report_mismatch("digit_position", 32'(digit_position),
						32'(next_digit.pos));
				if (last_digit !== next_digit.last)
					report_mismatch("last_digit", 32'(last_digit),
						32'(next_digit.last));
			end
		end
	end

	// drain outstanding digits, then let a zero-count transaction finish too
	task automatic settle();
		start <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [3:0] n);
		logic [31:0] w;
		w       = $urandom();
		w[3:0]  = n;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DIGITS;
		pwdata  <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		digit_count = n;
		count_settings++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_value(logic [31:0] v, int gap, logic typed, logic [31:0] syms);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		if (typed)
			typed_digits(syms, digit_count);
		else
			predict_digits(v, digit_count);
		values_sent++;
	endtask

	initial begin
		logic [3:0] n;
		logic       burst;
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		start          <= 1'b0;
		value          <= '0;
		digit_count    = DIGITS_RESET;
		err_count      = 0;
		digits_seen    = 0;
		values_sent    = 0;
		count_settings = 1;

		dir_table = '{
			'{4'd4,  32'd0,           1'b1, 32'({BL, BL, BL, 4'd0})},
			'{4'd4,  -32'd1,          1'b1, 32'({BL, BL, MI, 4'd1})},
			'{4'd4,  32'd1234,        1'b1, 32'h0000_1234},
			'{4'd4,  32'd12345,       1'b0, 32'd0},
			'{4'd4,  -32'd123,        1'b0, 32'd0},
			'{4'd4,  -32'd1234,       1'b1, 32'h0000_1234},
			'{4'd8,  32'h7FFF_FFFF,   1'b1, 32'h4748_3647},
			'{4'd8,  32'h8000_0000,   1'b1, 32'h4748_3648},
			'{4'd8,  32'd0,           1'b1, {BL, BL, BL, BL, BL, BL, BL, 4'd0}},
			'{4'd8,  -32'd5,          1'b1, {BL, BL, BL, BL, BL, BL, MI, 4'd5}},
			'{4'd8,  32'd90_000_000,  1'b1, 32'h9000_0000},
			'{4'd8,  -32'd9_999_999,  1'b0, 32'd0},
			'{4'd8,  -32'd10_000_000, 1'b1, 32'h1000_0000},
			'{4'd8,  32'd100,         1'b0, 32'd0},
			'{4'd8,  32'd305_419_896, 1'b0, 32'd0},
			'{4'd15, -32'd42,         1'b0, 32'd0},
			'{4'd15, 32'd67_890,      1'b0, 32'd0},
			'{4'd9,  32'd7,           1'b1, {BL, BL, BL, BL, BL, BL, BL, 4'd7}},
			'{4'd1,  -32'd1,          1'b1, 32'h0000_0001},
			'{4'd1,  32'd0,           1'b1, 32'h0000_0000},
			'{4'd1,  32'h8000_0000,   1'b1, 32'h0000_0008},
			'{4'd0,  32'd12345,       1'b1, 32'd0},
			'{4'd0,  -32'd1,          1'b1, 32'd0},
			'{4'd2,  -32'd7,          1'b1, 32'({MI, 4'd7})},
			'{4'd2,  -32'd10,         1'b0, 32'd0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			if (dir_table[i].ndig != digit_count) begin
				settle();
				cfg_write(dir_table[i].ndig);
			end
			send_value(dir_table[i].val, $urandom_range(0, 10),
				dir_table[i].typed, dir_table[i].syms);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       n = 4'd8;
				1:       n = 4'd1;
				2:       n = 4'd0;
				3:       n = 4'd15;
				default: n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				                                         : 4'($urandom_range(1, 8));
			endcase
			settle();
			cfg_write(n);
			burst = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS)
				send_value(rand_value(), burst ? 0 : $urandom_range(0, 10), 1'b0, 32'd0);
		end

		settle();
		$display("sent %0d values (%0d directed) under %0d digit-count settings",
			values_sent, DIR_ROWS, count_settings);
		$display("checked %0d digit codes, %0d mismatches", digits_seen, err_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[signed_decimal_seven_segment_formatter_core.f]
rtl/core/sdsf_pkg.sv
rtl/core/sdsf_div10.sv
rtl/core/signed_decimal_seven_segment_formatter_core.sv
tb/sv/signed_decimal_seven_segment_formatter_core_tb.sv
